// ===== hdl/assert_macros.svh =====
// assertion macros included by the hasher rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition");

`endif

// ===== hdl/sha256_pkg.sv =====
// sha-256 package: item types, round constants and initial hash values
// no dependencies
package sha256_pkg;

    localparam int ChunkBytes = 8;

    typedef struct packed {
        logic [63:0] chunk_bytes;
        logic [3:0]  byte_count;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_part0;
        logic [63:0] digest_part1;
        logic [63:0] digest_part2;
        logic [63:0] digest_part3;
    } t_out_item;

    typedef logic [31:0] t_word;

    localparam t_word InitChain [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundConsts [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam int LenPos = 56;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/sha256_message_hasher_top.sv =====
// sha-256 message hasher: byte loader, padding sequencer and one shared round unit
// depends on sha256_pkg and assert_macros.svh
//
// An item with n bytes (capped at CHUNK_BYTES) is taken in the idle state, then loads
// one byte per cycle straight into the schedule window (paused while a block is
// compressed); a non-final item then returns the block to idle. The last byte of a
// block is followed by the rounds (S_ROUND) and the addition into the chaining
// words (S_ADD). A final item then places the 0x80 byte, writes the zero padding
// (S_PAD) and the eight length bytes (S_LEN), runs one or two more compressions and
// hands the digest over (S_OUT). The round unit performs one round per cycle.
// o_stall is high whenever the block is not idle; i_stall holds o_item, and a new
// digest waits in its last state until the result register is free.
module sha256_message_hasher_top #(
    parameter int CHUNK_BYTES = sha256_pkg::ChunkBytes
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sha256_pkg::t_in_item  i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sha256_pkg::t_out_item o_item
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_PAD, S_LEN, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state r_state;
    logic [63:0] r_data;
    logic [3:0]  r_left;
    logic        r_last;
    logic        r_final;
    logic [63:0] r_total;
    logic [63:0] r_bits;
    logic [5:0]  r_pos;
    logic [6:0]  r_round;
    sha256_pkg::t_word r_chain [8];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_w [16];

    logic [3:0] n_cnt;
    always_comb begin
        n_cnt = (i_item.byte_count > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES)
                                                      : i_item.byte_count;
    end

    assign o_stall = (r_state != S_IDLE);

    // round unit
    logic [3:0] slot;
    sha256_pkg::t_word w2, w7, w15, w16, n_w, wk, t1, t2, a, e;
    always_comb begin
        slot = r_round[3:0];
        w2  = r_w[slot + 4'd14];
        w7  = r_w[slot + 4'd9];
        w15 = r_w[slot + 4'd1];
        w16 = r_w[slot];
        if (r_round[5:4] != 2'd0) begin
            n_w = (sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10))
                + w7
                + (sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3))
                + w16;
        end else begin
            n_w = w16;
        end
        wk = n_w + sha256_pkg::RoundConsts[r_round[5:0]];
        a = r_v[0];
        e = r_v[4];
        t1 = r_v[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
                     ^ sha256_pkg::rotr(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + wk;
        t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // block byte write port
    logic       blk_we;
    logic [7:0] blk_wd;
    always_comb begin
        blk_we = 1'b0;
        blk_wd = r_data[63:56];
        unique case (r_state)
            S_LOAD: blk_we = (r_left != 4'd0);
            S_PAD: begin
                blk_we = 1'b1;
                blk_wd = 8'h00;
            end
            S_LEN: begin
                blk_we = 1'b1;
                blk_wd = r_bits[63:56];
            end
            default: blk_we = 1'b0;
        endcase
    end

    // schedule window: bytes land in place, rounds roll it
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND) begin
            r_w[slot] <= n_w;
        end else if (blk_we) begin
            r_w[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= blk_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= 64'd0;
            r_pos   <= 6'd0;
            r_round <= 7'd0;
            r_left  <= 4'd0;
            r_last  <= 1'b0;
            r_final <= 1'b0;
            o_valid <= 1'b0;
            for (int i = 0; i < 8; i++) r_chain[i] <= sha256_pkg::InitChain[i];
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data  <= i_item.chunk_bytes;
                        r_left  <= n_cnt;
                        r_last  <= i_item.end_of_message;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_left != 4'd0) begin
                        r_data  <= r_data << 8;
                        r_left  <= r_left - 4'd1;
                        r_pos   <= r_pos + 6'd1;
                        r_total <= r_total + 64'd1;
                        if (r_pos == 6'd63) begin
                            r_round <= 7'd0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
                            r_state <= S_ROUND;
                        end
                    end else if (r_last) begin
                        r_bits  <= {r_total[60:0], 3'b000};
                        r_data  <= {sha256_pkg::PadByte, 56'd0};
                        r_left  <= 4'd1;
                        r_last  <= 1'b0;
                        r_final <= 1'b1;
                    end else if (r_final) begin
                        // pad byte placed; fill zeros up to the length field
                        r_state <= (r_pos == 6'(sha256_pkg::LenPos)) ? S_LEN : S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_round <= 7'd0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
                        r_state <= S_ROUND;
                    end else if (r_pos == 6'(sha256_pkg::LenPos - 1)) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_pos  <= r_pos + 6'd1;
                    r_bits <= r_bits << 8;
                    if (r_pos == 6'd63) begin
                        r_round <= 7'd0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= e;
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= a;
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
                    if (r_final && r_pos == 6'd0 && r_bits == 64'd0 && r_left == 4'd0) begin
                        r_state <= S_OUT;
                    end else if (r_final && r_pos == 6'd0 && r_left == 4'd0
                                 && r_total[5:0] != 6'd0 && r_total[5:0] < 6'd56
                                 ) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_item.digest_part0 <= {r_chain[0], r_chain[1]};
                        o_item.digest_part1 <= {r_chain[2], r_chain[3]};
                        o_item.digest_part2 <= {r_chain[4], r_chain[5]};
                        o_item.digest_part3 <= {r_chain[6], r_chain[7]};
                        o_valid <= 1'b1;
                        for (int i = 0; i < 8; i++) r_chain[i] <= sha256_pkg::InitChain[i];
                        r_total <= 64'd0;
                        r_final <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // after a length block the stream position is back to zero with no bits pending:
    // len phase shifts r_bits out entirely, so r_bits == 0 marks the final block done

    `ASSERT_IMPL(a_round_only_in_round, i_clk, i_rst_n,
        (r_state == S_ROUND) |-> (r_round < 7'd64))
    `ASSERT_IMPL(a_round_ends_in_add, i_clk, i_rst_n,
        (r_state == S_ROUND && r_round == 7'd63) |=> (r_state == S_ADD))
    `ASSERT_NEVER(a_busy_accept, i_clk, i_rst_n,
        (r_state != S_IDLE) && !o_stall)

endmodule

// ===== tb/sha256_message_hasher_top_tb.sv =====
// testbench for sha256_message_hasher_top: drives directed and random messages, predicts each digest
// with its own sha-256 model and compares every item on o_item
// depends on sha256_pkg and the hasher rtl
module sha256_message_hasher_top_tb;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    sha256_pkg::t_in_item  i_item = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    sha256_pkg::t_out_item o_item;

    sha256_message_hasher_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_len_bytes;

    sha256_pkg::t_in_item  pending_items [$];
    sha256_pkg::t_out_item digest_queue [$];
    int        mismatch_count = 0;
    int        digests_checked = 0;
    int        messages_sent = 0;
    bit        stim_done = 1'b0;
    bit        drain_request = 1'b0;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundConsts[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitChain[i];
        msg_len_bytes = '0;
    endtask

    task automatic predict_digest(sha256_pkg::t_in_item it);
        int n;
        int p;
        logic [63:0] bit_len;
        sha256_pkg::t_out_item d;
        n = (it.byte_count > sha256_pkg::ChunkBytes) ? sha256_pkg::ChunkBytes
                                                     : int'(it.byte_count);
        for (int i = 0; i < n; i++) begin
            p = int'(msg_len_bytes[5:0]);
            msg_block[p] = it.chunk_bytes[63 - 8*i -: 8];
            msg_len_bytes++;
            if (p == 63) hash_block();
        end
        if (!it.end_of_message) return;
        bit_len = msg_len_bytes << 3;
        p = int'(msg_len_bytes[5:0]);
        msg_block[p] = sha256_pkg::PadByte;
        p++;
        if (p > sha256_pkg::LenPos) begin
            while (p < 64) begin msg_block[p] = 8'h00; p++; end
            hash_block();
            p = 0;
        end
        while (p < sha256_pkg::LenPos) begin msg_block[p] = 8'h00; p++; end
        for (int i = 0; i < 8; i++)
            msg_block[sha256_pkg::LenPos + i] = bit_len[63 - 8*i -: 8];
        hash_block();
        d.digest_part0 = {hash_state[0], hash_state[1]};
        d.digest_part1 = {hash_state[2], hash_state[3]};
        d.digest_part2 = {hash_state[4], hash_state[5]};
        d.digest_part3 = {hash_state[6], hash_state[7]};
        digest_queue.push_back(d);
        hash_restart();
    endtask

    function automatic sha256_pkg::t_in_item make_chunk(logic [63:0] data, int cnt, bit last);
        sha256_pkg::t_in_item it;
        it.chunk_bytes = data;
        it.byte_count = 4'(cnt);
        it.end_of_message = last;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // driver
    int                   send_gap = 0;
    sha256_pkg::t_in_item drive_item;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_digest(i_item);
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !drain_request) begin
                    drive_item = pending_items.pop_front();
                    i_item <= drive_item;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int recv_wait = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (digest_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected digest %h", o_item);
                end else begin
                    sha256_pkg::t_out_item e;
                    e = digest_queue.pop_front();
                    digests_checked++;
                    if (o_item.digest_part0 !== e.digest_part0 ||
                        o_item.digest_part1 !== e.digest_part1 ||
                        o_item.digest_part2 !== e.digest_part2 ||
                        o_item.digest_part3 !== e.digest_part3) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("digest mismatch: expected %h got %h", e, o_item);
                    end
                end
                recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic queue_message(int nbytes, bit noisy);
        int left;
        int c;
        left = nbytes;
        while (left > 8) begin
            c = noisy ? $urandom_range(0, 15) : $urandom_range(1, 8);
            if (c == 0 && $urandom_range(0, 1)) c = 0;
            pending_items.push_back(make_chunk(rand64(), c, 1'b0));
            left -= (c > 8) ? 8 : c;
        end
        c = left;
        if (noisy && c == 8 && $urandom_range(0, 1)) c = $urandom_range(9, 15);
        pending_items.push_back(make_chunk(rand64(), c, 1'b1));
        messages_sent++;
    endtask

    initial begin
        int sz;
        hash_restart();
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        // directed: empty message, "abc", extremes, oversized count, empty chunks
        pending_items.push_back(make_chunk(64'h0, 0, 1'b1));
        pending_items.push_back(make_chunk(64'h6162_6300_0000_0000, 3, 1'b1));
        pending_items.push_back(make_chunk('1, 8, 1'b0));
        pending_items.push_back(make_chunk(64'h0, 0, 1'b0));
        pending_items.push_back(make_chunk('1, 15, 1'b0));
        pending_items.push_back(make_chunk(64'h0, 8, 1'b1));
        for (int i = 0; i < 7; i++) pending_items.push_back(make_chunk('1, 8, 1'b0));
        pending_items.push_back(make_chunk(64'h0123_4567_89ab_cdef, 7, 1'b1));
        for (int i = 0; i < 7; i++) pending_items.push_back(make_chunk(64'h0, 8, 1'b0));
        pending_items.push_back(make_chunk('1, 8, 1'b1));
        pending_items.push_back(make_chunk(64'h5555_aaaa_5555_aaaa, 1, 1'b1));
        pending_items.push_back(make_chunk(64'h0, 0, 1'b1));
        messages_sent += 7;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() < 1650) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 70);
            queue_message(sz, $urandom_range(0, 3) == 0);
        end
        // midway pause: stop sending until all expected digests are drained
        wait (pending_items.size() < 800);
        drain_request = 1'b1;
        wait (!i_valid && digest_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        drain_request = 1'b0;
        wait (pending_items.size() == 0 && !i_valid);
        wait (digest_queue.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("hashed %0d messages over about 1650 chunks, %0d digests compared",
                 messages_sent, digests_checked);
        if (mismatch_count == 0 && digest_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #30000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/sha256_pkg.sv
hdl/sha256_message_hasher_top.sv
tb/sha256_message_hasher_top_tb.sv
